// ===== hw/rtl/gdfo_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, command and result codes, and control/status bundles
// for the depth-first order block. No dependencies.
package gdfo_pkg;

  localparam int CMD_W  = 2;
  localparam int VTX_W  = 6;
  localparam int KIND_W = 2;
  localparam int CFG_W  = 7;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_VISIT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEARED = 2'd3;

  localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd1;

  typedef struct packed {
    logic ld_app;
    logic app_exec;
    logic clr_exec;
    logic run_start;
    logic run_rd;
    logic step;
    logic push;
    logic pop;
    logic pop_load;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic has_nb;
    logic take_nb;
    logic depth_one;
  } dp_stat_t;

endpackage

// ===== hw/rtl/gdfo_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: command words in, result words out,
// and the vertex count write channel. Depends on gdfo_pkg.
interface gdfo_in_if;
  logic                         valid;
  logic                         ready;
  logic [gdfo_pkg::CMD_W-1:0]   cmd;
  logic [gdfo_pkg::VTX_W-1:0]   owner_vertex;
  logic [gdfo_pkg::VTX_W-1:0]   neighbor_vertex;
  modport source (output valid, cmd, owner_vertex, neighbor_vertex, input ready);
  modport sink   (input valid, cmd, owner_vertex, neighbor_vertex, output ready);
endinterface

interface gdfo_out_if;
  logic                         valid;
  logic                         ready;
  logic [gdfo_pkg::KIND_W-1:0]  kind;
  logic [gdfo_pkg::VTX_W-1:0]   vertex;
  logic                         last;
  modport source (output valid, kind, vertex, last, input ready);
  modport sink   (input valid, kind, vertex, last, output ready);
endinterface

interface gdfo_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [gdfo_pkg::CFG_W-1:0]   vertex_count;
  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

// ===== hw/rtl/gdfo_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for append, clear and depth-first run commands.
// Depends on gdfo_pkg and gdfo_if; drives the datapath through ctrl_cmd_t.
module gdfo_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  gdfo_in_if.sink               in_ch,
  input  gdfo_pkg::dp_stat_t    stat,
  output gdfo_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_APP   = 7'b0000010,
    S_CLR   = 7'b0000100,
    S_RD    = 7'b0001000,
    S_EV    = 7'b0010000,
    S_POP   = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && (state_r == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.ld_app    = accept && (in_ch.cmd == gdfo_pkg::CMD_APPEND);
    cmd.run_start = accept && (in_ch.cmd == gdfo_pkg::CMD_RUN);
    cmd.app_exec  = (state_r == S_APP) && stat.out_free;
    cmd.clr_exec  = (state_r == S_CLR) && stat.out_free;
    cmd.run_rd    = (state_r == S_RD);
    cmd.step      = (state_r == S_EV) && stat.has_nb && !stat.take_nb;
    cmd.push      = (state_r == S_EV) && stat.take_nb && stat.out_free;
    cmd.pop       = (state_r == S_EV) && !stat.has_nb;
    cmd.pop_load  = (state_r == S_POP);
    cmd.flush     = (state_r == S_FLUSH) && stat.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.cmd)
            gdfo_pkg::CMD_APPEND: state_nxt = S_APP;
            gdfo_pkg::CMD_RUN:    state_nxt = S_RD;
            gdfo_pkg::CMD_CLEAR:  state_nxt = S_CLR;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_APP:   if (stat.out_free) state_nxt = S_IDLE;
      S_CLR:   if (stat.out_free) state_nxt = S_IDLE;
      S_RD:    state_nxt = S_EV;
      S_EV: begin
        if (!stat.has_nb) begin
          state_nxt = stat.depth_one ? S_FLUSH : S_POP;
        end else if (!stat.take_nb || stat.out_free) begin
          state_nxt = S_RD;
        end
      end
      S_POP:   state_nxt = S_RD;
      S_FLUSH: if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/gdfo_dp.sv =====
`timescale 1ns / 1ps
// Datapath: neighbor list memory, degree table, visited map, walk stack,
// vertex count register and result register. Depends on gdfo_pkg, gdfo_if.
module gdfo_dp #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gdfo_pkg::ctrl_cmd_t           cmd,
  output gdfo_pkg::dp_stat_t            stat,
  input  logic [gdfo_pkg::VTX_W-1:0]    in_owner,
  input  logic [gdfo_pkg::VTX_W-1:0]    in_neighbor,
  gdfo_cfg_if.sink                      cfg_ch,
  gdfo_out_if.source                    out_ch
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NV = 1 << AW;
  localparam int DW = $clog2(MAX_VERTICES + 1);
  localparam int VW = gdfo_pkg::VTX_W;
  localparam int SW = DW + VW;
  localparam logic [DW-1:0] DEG_FULL = DW'(MAX_VERTICES);
  localparam logic [gdfo_pkg::CFG_W-1:0] MAXV = gdfo_pkg::CFG_W'(MAX_VERTICES);

  logic [gdfo_pkg::CFG_W-1:0]  vc_r;
  logic [gdfo_pkg::CFG_W-1:0]  n_eff;
  logic [VW-1:0]               own_r, nb_r;
  logic [VW-1:0]               cur_v_r;
  logic [DW-1:0]               cur_idx_r;
  logic [DW-1:0]               depth_r;
  logic [NV-1:0]               visited_r;
  logic [VW-1:0]               pend_v_r;

  logic [DW-1:0]               deg_mem [NV];
  logic [NV-1:0]               deg_vld_r;
  logic [DW-1:0]               deg_q_r;
  logic                        deg_vq_r;
  logic [DW-1:0]               deg_eff;
  logic [AW-1:0]               deg_addr;

  logic [VW-1:0]               adj_mem [NV*NV];
  logic [VW-1:0]               adj_q_r;
  logic [2*AW-1:0]             adj_addr;
  logic                        adj_we;

  logic [SW-1:0]               stk_mem [NV];
  logic [SW-1:0]               stk_q_r;
  logic [DW-1:0]               push_pos, pop_pos;

  logic                        out_valid_r;
  logic [gdfo_pkg::KIND_W-1:0] out_kind_r;
  logic [VW-1:0]               out_vertex_r;
  logic                        out_last_r;
  logic                        out_load;
  logic                        out_free;
  logic                        reject;
  logic                        has_nb, take_nb;

  assign cfg_ch.ready = 1'b1;

  assign n_eff = (vc_r == '0) ? gdfo_pkg::CFG_W'(1) : ((vc_r > MAXV) ? MAXV : vc_r);

  assign deg_eff = deg_vq_r ? deg_q_r : '0;
  assign has_nb  = cur_idx_r < deg_eff;
  assign take_nb = has_nb && ({1'b0, adj_q_r} < n_eff) && !visited_r[adj_q_r[AW-1:0]];
  assign reject  = ({1'b0, own_r} >= MAXV) || (deg_eff == DEG_FULL);

  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = cmd.app_exec || cmd.clr_exec || cmd.push || cmd.flush;

  assign stat.out_free  = out_free;
  assign stat.has_nb    = has_nb;
  assign stat.take_nb   = take_nb;
  assign stat.depth_one = (depth_r == DW'(1));

  assign deg_addr = cmd.ld_app ? in_owner[AW-1:0] : cur_v_r[AW-1:0];
  assign adj_addr = cmd.app_exec ? {own_r[AW-1:0], deg_eff[AW-1:0]}
                                 : {cur_v_r[AW-1:0], cur_idx_r[AW-1:0]};
  assign adj_we   = cmd.app_exec && !reject;
  assign push_pos = depth_r - DW'(1);
  assign pop_pos  = depth_r - DW'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= gdfo_pkg::VCOUNT_RESET;
    end else if (cfg_ch.valid) begin
      vc_r <= cfg_ch.vertex_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_app) begin
      own_r <= in_owner;
      nb_r  <= in_neighbor;
    end
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_addr] <= nb_r;
    end
    if (cmd.run_rd) begin
      adj_q_r <= adj_mem[adj_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      deg_mem[own_r[AW-1:0]] <= deg_eff + DW'(1);
    end
    if (cmd.ld_app || cmd.run_rd) begin
      deg_q_r  <= deg_mem[deg_addr];
      deg_vq_r <= deg_vld_r[deg_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_vld_r <= '0;
    end else if (cmd.clr_exec) begin
      deg_vld_r <= '0;
    end else if (adj_we) begin
      deg_vld_r[own_r[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem[push_pos[AW-1:0]] <= {cur_idx_r + DW'(1), cur_v_r};
    end
    if (cmd.pop) begin
      stk_q_r <= stk_mem[pop_pos[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= '0;
      visited_r <= '0;
    end else if (cmd.run_start) begin
      depth_r   <= DW'(1);
      visited_r <= NV'(1);
    end else if (cmd.push) begin
      depth_r   <= depth_r + DW'(1);
      visited_r[adj_q_r[AW-1:0]] <= 1'b1;
    end else if (cmd.pop) begin
      depth_r   <= depth_r - DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      cur_v_r   <= '0;
      cur_idx_r <= '0;
      pend_v_r  <= '0;
    end else if (cmd.push) begin
      cur_v_r   <= adj_q_r;
      cur_idx_r <= '0;
      pend_v_r  <= adj_q_r;
    end else if (cmd.step) begin
      cur_idx_r <= cur_idx_r + DW'(1);
    end else if (cmd.pop_load) begin
      cur_v_r   <= stk_q_r[VW-1:0];
      cur_idx_r <= stk_q_r[SW-1:VW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.app_exec) begin
      out_kind_r   <= reject ? gdfo_pkg::KIND_REJECT : gdfo_pkg::KIND_ACCEPT;
      out_vertex_r <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.clr_exec) begin
      out_kind_r   <= gdfo_pkg::KIND_CLEARED;
      out_vertex_r <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.push || cmd.flush) begin
      out_kind_r   <= gdfo_pkg::KIND_VISIT;
      out_vertex_r <= pend_v_r;
      out_last_r   <= cmd.flush;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.kind   = out_kind_r;
  assign out_ch.vertex = out_vertex_r;
  assign out_ch.last   = out_last_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEG_FULL)
    else $error("walk stack depth above vertex limit");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (depth_r < DEG_FULL) && (adj_q_r[AW-1:0] != '0))
    else $error("push without stack room or of the root vertex");

  a_root_seen: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run_rd |-> visited_r[0] && (depth_r != '0))
    else $error("walk active without root visited or with empty stack");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register overwritten while held");

endmodule

// ===== hw/rtl/graph_depth_first_order.sv =====
`timescale 1ns / 1ps
// Top level of the depth-first order block: sequencer plus datapath.
// Depends on gdfo_pkg, gdfo_if, gdfo_ctrl and gdfo_dp.
//
// Append and clear words each answer with one result word;
// a run word answers with the vertices reached from vertex 0 in depth-first
// discovery order, last set on the final one. Each neighbor entry is examined
// through a registered read of the single-port neighbor memory followed by an
// evaluate state, and each return from a vertex adds one stack memory read.
// Output back-pressure stalls the walk. A new command word is taken only
// after the previous one has produced its last result.
module graph_depth_first_order #(
  parameter int MAX_VERTICES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  gdfo_in_if.sink     in_ch,
  gdfo_out_if.source  out_ch,
  gdfo_cfg_if.sink    cfg_ch
);

  gdfo_pkg::ctrl_cmd_t cmd;
  gdfo_pkg::dp_stat_t  stat;

  gdfo_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .stat  (stat),
    .cmd   (cmd)
  );

  gdfo_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_owner    (in_ch.owner_vertex),
    .in_neighbor (in_ch.neighbor_vertex),
    .cfg_ch      (cfg_ch),
    .out_ch      (out_ch)
  );

endmodule

// ===== dv/graph_depth_first_order_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for graph_depth_first_order: drives command words,
// predicts the depth-first visiting order and checks every result word.
// Depends on gdfo_pkg, the gdfo_if channel interfaces and the RTL.
module graph_depth_first_order_tb;

  localparam int MAX_V         = 64;
  localparam int NO_WRITE      = -1;
  localparam int ITEM_TARGET   = 450;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 40000;
  localparam int SHOWN_ERRORS  = 10;

  localparam logic [gdfo_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [gdfo_pkg::KIND_W-1:0] kind;
    logic [gdfo_pkg::VTX_W-1:0]  vertex;
    logic                        last;
  } result_t;

  typedef struct {
    int                         count_write;
    logic [gdfo_pkg::CMD_W-1:0] cmd;
    logic [gdfo_pkg::VTX_W-1:0] owner;
    logic [gdfo_pkg::VTX_W-1:0] nbr;
    int                         reps;
    bit                         typed;
    result_t                    want;
  } dir_row_t;

  localparam result_t VISIT_ROOT = '{gdfo_pkg::KIND_VISIT, 6'd0, 1'b1};
  localparam result_t ACCEPTED   = '{gdfo_pkg::KIND_ACCEPT, 6'd0, 1'b1};
  localparam result_t REJECTED   = '{gdfo_pkg::KIND_REJECT, 6'd0, 1'b1};
  localparam result_t CLEARED    = '{gdfo_pkg::KIND_CLEARED, 6'd0, 1'b1};
  localparam result_t NO_RESULT  = '{gdfo_pkg::KIND_VISIT, 6'd0, 1'b0};

  logic clk;
  logic rst_n;

  gdfo_in_if  in_ch ();
  gdfo_out_if out_ch ();
  gdfo_cfg_if cfg_ch ();

  graph_depth_first_order #(.MAX_VERTICES(MAX_V)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [gdfo_pkg::VTX_W-1:0] adj_mem [MAX_V][MAX_V];
  logic [6:0]                 degree [MAX_V] = '{default: '0};
  logic [gdfo_pkg::CFG_W-1:0] count_reg = gdfo_pkg::VCOUNT_RESET;

  result_t pending_results [$];
  int      mismatch_cnt = 0;
  int      words_sent = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_left = 0;
  int      cur_n = 1;

  dir_row_t dir_rows [21] = '{
    '{NO_WRITE, gdfo_pkg::CMD_RUN,    6'd0,  6'd0,  1,  1, VISIT_ROOT},
    '{NO_WRITE, CMD_UNUSED,           6'd21, 6'd42, 1,  0, NO_RESULT},
    '{NO_WRITE, gdfo_pkg::CMD_APPEND, 6'd0,  6'd63, 1,  1, ACCEPTED},
    '{NO_WRITE, gdfo_pkg::CMD_APPEND, 6'd63, 6'd0,  1,  1, ACCEPTED},
    '{NO_WRITE, gdfo_pkg::CMD_RUN,    6'd0,  6'd0,  1,  1, VISIT_ROOT},
    '{64,       gdfo_pkg::CMD_APPEND, 6'd0,  6'd1,  1,  1, ACCEPTED},
    '{NO_WRITE, gdfo_pkg::CMD_APPEND, 6'd1,  6'd2,  1,  0, NO_RESULT},
    '{NO_WRITE, gdfo_pkg::CMD_APPEND, 6'd2,  6'd0,  1,  0, NO_RESULT},
    '{NO_WRITE, gdfo_pkg::CMD_APPEND, 6'd1,  6'd3,  1,  0, NO_RESULT},
    '{NO_WRITE, gdfo_pkg::CMD_APPEND, 6'd0,  6'd3,  1,  0, NO_RESULT},
    '{NO_WRITE, gdfo_pkg::CMD_RUN,    6'd0,  6'd0,  1,  0, NO_RESULT},
    '{NO_WRITE, gdfo_pkg::CMD_CLEAR,  6'd0,  6'd0,  1,  1, CLEARED},
    '{NO_WRITE, gdfo_pkg::CMD_RUN,    6'd63, 6'd63, 1,  1, VISIT_ROOT},
    '{NO_WRITE, gdfo_pkg::CMD_APPEND, 6'd7,  6'd42, 64, 1, ACCEPTED},
    '{NO_WRITE, gdfo_pkg::CMD_APPEND, 6'd7,  6'd21, 1,  1, REJECTED},
    '{NO_WRITE, gdfo_pkg::CMD_APPEND, 6'd0,  6'd7,  1,  1, ACCEPTED},
    '{NO_WRITE, gdfo_pkg::CMD_RUN,    6'd0,  6'd0,  1,  0, NO_RESULT},
    '{0,        gdfo_pkg::CMD_RUN,    6'd0,  6'd0,  1,  1, VISIT_ROOT},
    '{127,      gdfo_pkg::CMD_RUN,    6'd0,  6'd0,  1,  0, NO_RESULT},
    '{8,        gdfo_pkg::CMD_RUN,    6'd0,  6'd0,  1,  0, NO_RESULT},
    '{NO_WRITE, gdfo_pkg::CMD_CLEAR,  6'd63, 6'd63, 1,  1, CLEARED}
  };

  function automatic void dfs_results_for(input logic [gdfo_pkg::CMD_W-1:0] c,
                                           input logic [gdfo_pkg::VTX_W-1:0] own,
                                           input logic [gdfo_pkg::VTX_W-1:0] nb,
                                           ref result_t res [$]);
    int                         n;
    int                         sp;
    int                         top;
    logic [gdfo_pkg::VTX_W-1:0] v;
    logic [gdfo_pkg::VTX_W-1:0] nbr;
    logic [6:0]                 idx;
    logic [12:0]                walk [MAX_V];
    bit                         seen [MAX_V];
    res.delete();
    case (c)
      gdfo_pkg::CMD_APPEND: begin
        if (degree[own] >= MAX_V) begin
          res.push_back(REJECTED);
        end else begin
          adj_mem[own][degree[own]] = nb;
          degree[own] = degree[own] + 7'd1;
          res.push_back(ACCEPTED);
        end
      end
      gdfo_pkg::CMD_RUN: begin
        n = (count_reg > MAX_V) ? MAX_V : ((count_reg == 0) ? 1 : int'(count_reg));
        seen = '{default: 1'b0};
        seen[0] = 1'b1;
        res.push_back(result_t'{gdfo_pkg::KIND_VISIT, 6'd0, 1'b0});
        walk[0] = '0;
        sp = 1;
        while (sp > 0) begin
          top = sp - 1;
          v = walk[top][5:0];
          idx = walk[top][12:6];
          if (idx < degree[v] && idx < MAX_V) begin
            nbr = adj_mem[v][idx];
            walk[top][12:6] = idx + 7'd1;
            if (nbr < n && !seen[nbr] && res.size() < MAX_V && sp < MAX_V) begin
              seen[nbr] = 1'b1;
              res.push_back(result_t'{gdfo_pkg::KIND_VISIT, nbr, 1'b0});
              walk[sp] = {7'd0, nbr};
              sp++;
            end
          end else begin
            sp--;
          end
        end
        res[res.size()-1].last = 1'b1;
      end
      gdfo_pkg::CMD_CLEAR: begin
        degree = '{default: '0};
        res.push_back(CLEARED);
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [gdfo_pkg::CMD_W-1:0] c,
                           input logic [gdfo_pkg::VTX_W-1:0] own,
                           input logic [gdfo_pkg::VTX_W-1:0] nb,
                           input bit typed, input result_t want);
    result_t res [$];
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid           <= 1'b1;
    in_ch.cmd             <= c;
    in_ch.owner_vertex    <= own;
    in_ch.neighbor_vertex <= nb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    dfs_results_for(c, own, nb, res);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (res[i]) pending_results.push_back(res[i]);
    end
    if (c != CMD_UNUSED) words_sent++;
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [gdfo_pkg::CFG_W-1:0] vc);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.vertex_count <= vc;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    count_reg = vc;
    cur_n = (vc > MAX_V) ? MAX_V : ((vc == 0) ? 1 : int'(vc));
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.kind, out_ch.vertex, out_ch.last};
      if (pending_results.size() == 0) begin
        if (mismatch_cnt < SHOWN_ERRORS)
          $display("unexpected result word: kind %0d vertex %0d last %0d",
                   got.kind, got.vertex, got.last);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatch_cnt < SHOWN_ERRORS)
            $display({"result mismatch: expected kind %0d vertex %0d last %0d, ",
                      "got kind %0d vertex %0d last %0d"},
                     want.kind, want.vertex, want.last, got.kind, got.vertex, got.last);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("graph_depth_first_order_tb failed");
    $finish;
  end

  initial begin
    int                         phase_no;
    int                         sel;
    int                         edges;
    int                         j;
    int                         tmp;
    int                         perm [MAX_V];
    logic [gdfo_pkg::VTX_W-1:0] own;
    logic [gdfo_pkg::VTX_W-1:0] nbv;
    logic [gdfo_pkg::VTX_W-1:0] prev;
    logic [gdfo_pkg::CFG_W-1:0] vc;

    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.cmd             <= gdfo_pkg::CMD_APPEND;
    in_ch.owner_vertex    <= '0;
    in_ch.neighbor_vertex <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.vertex_count   <= gdfo_pkg::VCOUNT_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].count_write != NO_WRITE) begin
        wait_quiet();
        write_count(dir_rows[i].count_write[gdfo_pkg::CFG_W-1:0]);
      end
      repeat (dir_rows[i].reps)
        send_word(dir_rows[i].cmd, dir_rows[i].owner, dir_rows[i].nbr,
                  dir_rows[i].typed, dir_rows[i].want);
    end

    phase_no = 0;
    while (words_sent < ITEM_TARGET) begin
      phase_no++;
      case (phase_no % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      case ($urandom_range(7))
        0: vc = 7'd1;
        1: vc = 7'd64;
        2: vc = 7'd2;
        3: vc = 7'($urandom_range(65, 127));
        4: vc = 7'd0;
        default: vc = 7'($urandom_range(1, 64));
      endcase
      wait_quiet();
      write_count(vc);
      if (phase_no == 2) hold_left = HOLD_CYCLES;

      repeat (2) begin
        sel = $urandom_range(11);
        if (sel <= 6) begin
          send_word(gdfo_pkg::CMD_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)), 0,
                    NO_RESULT);
          edges = $urandom_range(0, 2 * cur_n);
          for (j = 0; j < edges; j++) begin
            own = ($urandom_range(9) != 0) ? 6'($urandom_range(cur_n - 1))
                                           : 6'($urandom_range(63));
            nbv = ($urandom_range(6) != 0) ? 6'($urandom_range(cur_n - 1))
                                           : 6'($urandom_range(63));
            if ($urandom_range(19) == 0)
              send_word(CMD_UNUSED, 6'($urandom_range(63)), 6'($urandom_range(63)), 0,
                        NO_RESULT);
            send_word(gdfo_pkg::CMD_APPEND, own, nbv, 0, NO_RESULT);
          end
          if ($urandom_range(3) == 0) wait_quiet();
          send_word(gdfo_pkg::CMD_RUN, 6'($urandom_range(63)), 6'($urandom_range(63)), 0,
                    NO_RESULT);
        end else if (sel <= 9) begin
          // Chain every vertex in shuffled order to drive the stack to full depth.
          send_word(gdfo_pkg::CMD_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)), 0,
                    NO_RESULT);
          for (j = 1; j < cur_n; j++) perm[j] = j;
          for (j = cur_n - 1; j > 1; j--) begin
            sel = $urandom_range(1, j);
            tmp = perm[j];
            perm[j] = perm[sel];
            perm[sel] = tmp;
          end
          prev = '0;
          for (j = 1; j < cur_n; j++) begin
            if ($urandom_range(4) == 0)
              send_word(gdfo_pkg::CMD_APPEND, prev, 6'($urandom_range(cur_n - 1)), 0,
                        NO_RESULT);
            send_word(gdfo_pkg::CMD_APPEND, prev, 6'(perm[j]), 0, NO_RESULT);
            prev = 6'(perm[j]);
          end
          send_word(gdfo_pkg::CMD_RUN, 6'($urandom_range(63)), 6'($urandom_range(63)), 0,
                    NO_RESULT);
        end else if (sel == 10) begin
          // Fill one list past its capacity, then link it from the root.
          send_word(gdfo_pkg::CMD_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)), 0,
                    NO_RESULT);
          own = 6'($urandom_range(cur_n - 1));
          repeat (MAX_V + 2)
            send_word(gdfo_pkg::CMD_APPEND, own, 6'($urandom_range(63)), 0, NO_RESULT);
          send_word(gdfo_pkg::CMD_APPEND, 6'd0, own, 0, NO_RESULT);
          send_word(gdfo_pkg::CMD_RUN, 6'($urandom_range(63)), 6'($urandom_range(63)), 0,
                    NO_RESULT);
        end else begin
          repeat ($urandom_range(5, 15))
            send_word(2'($urandom_range(3)), 6'($urandom_range(63)),
                      6'($urandom_range(63)), 0, NO_RESULT);
        end
      end
    end

    wait_quiet();
    if (mismatch_cnt == 0 && pending_results.size() == 0)
      $display("graph_depth_first_order_tb passed");
    else
      $display("graph_depth_first_order_tb failed");
    $finish;
  end

endmodule
